### rtl/prai_pkg.sv
`timescale 1ns / 1ps

package prai_pkg;

    localparam int POS_W   = 32;
    localparam int Q_W     = 18;
    localparam int D_W     = POS_W + 1;
    localparam int XY_W    = 34;
    localparam int Z_W     = 35;
    localparam int IDX_W   = 3;
    localparam int ATAN_N  = 24;
    localparam int DOT_W   = 54;
    localparam int DOTR_W  = DOT_W - 16;
    localparam int TERM_W  = 60;
    localparam int TR_W    = TERM_W - 16;
    localparam int R_W     = 37;
    localparam int OMC_W   = 19;

    localparam logic signed [Q_W-1:0]  ONE_Q16      = 18'sd65536;
    localparam logic signed [Q_W-1:0]  ANGLE_LIMIT  = 18'sd102944;
    localparam logic signed [Z_W-1:0]  PI_Q30       = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30  = 35'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30     = 34'sd652032874;

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_AXIS_X     = 3'd3,
        REG_AXIS_Y     = 3'd4,
        REG_AXIS_Z     = 3'd5,
        REG_TURN_ANGLE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                  busy;
        logic signed [Q_W-1:0] cos_v;
        logic signed [Q_W-1:0] sin_v;
    } trig_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            5'd0:  r = 35'sd843314857;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043837;
            5'd3:  r = 35'sd133525159;
            5'd4:  r = 35'sd67021687;
            5'd5:  r = 35'sd33543516;
            5'd6:  r = 35'sd16775851;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194283;
            5'd9:  r = 35'sd2097151;
            5'd10: r = 35'sd1048576;
            5'd11: r = 35'sd524288;
            5'd12: r = 35'sd262144;
            5'd13: r = 35'sd131072;
            5'd14: r = 35'sd65536;
            5'd15: r = 35'sd32768;
            5'd16: r = 35'sd16384;
            5'd17: r = 35'sd8192;
            5'd18: r = 35'sd4096;
            5'd19: r = 35'sd2048;
            5'd20: r = 35'sd1024;
            5'd21: r = 35'sd512;
            5'd22: r = 35'sd256;
            5'd23: r = 35'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] clamp_unit(input logic signed [39:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 40'sd65536)
            r = ONE_Q16;
        else if (v < -40'sd65536)
            r = -ONE_Q16;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

### rtl/prai_cordic.sv
`timescale 1ns / 1ps

module prai_cordic #(
    parameter int ITER = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [prai_pkg::Z_W-1:0]    angle,
    output prai_pkg::trig_t                    trig
);

    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ITER - 1);

    logic                               busy_reg, busy_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic signed [prai_pkg::XY_W-1:0]   x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [prai_pkg::Z_W-1:0]    z_reg, z_next, z0, at;
    logic                               neg_reg, neg_next;
    logic signed [prai_pkg::XY_W:0]     xf, yf, xr, yr;

    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = prai_pkg::atan_q30(5'(cnt_reg));
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        if (angle > prai_pkg::HALF_PI_Q30)
            z0 = angle - prai_pkg::PI_Q30;
        else if (angle < -prai_pkg::HALF_PI_Q30)
            z0 = angle + prai_pkg::PI_Q30;
        else
            z0 = angle;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = prai_pkg::GAIN_Q30;
            y_next    = '0;
            z_next    = z0;
            neg_next  = (angle > prai_pkg::HALF_PI_Q30) || (angle < -prai_pkg::HALF_PI_Q30);
        end
        else if (busy_reg)
        begin
            if (!z_reg[prai_pkg::Z_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        xf = neg_reg ? -(prai_pkg::XY_W+1)'(x_reg) : (prai_pkg::XY_W+1)'(x_reg);
        yf = neg_reg ? -(prai_pkg::XY_W+1)'(y_reg) : (prai_pkg::XY_W+1)'(y_reg);
        xr = (xf + (prai_pkg::XY_W+1)'(8192)) >>> 14;
        yr = (yf + (prai_pkg::XY_W+1)'(8192)) >>> 14;
        trig.busy  = busy_reg;
        trig.cos_v = prai_pkg::clamp_unit(40'(xr));
        trig.sin_v = prai_pkg::clamp_unit(40'(yr));
    end

endmodule

### rtl/pose_rotation_about_axis.sv
`timescale 1ns / 1ps

// Throughput: one pose per cycle while in_stall is low.
// The five register stages are set by the product chain a.d, a*(a.d), t*(1-cos).
// After reset and after each turn_angle write, input stalls while two CORDIC units
// are started, run TRIG_ITERATIONS iterations and settle; other writes stall input
// until the settle counter expires.
// Reset clears the registers to origin 0, axis (0, 0, 1), angle 0, pipeline empty.

module pose_rotation_about_axis #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [31:0]    pos_x,
    input  logic signed [31:0]    pos_y,
    input  logic signed [31:0]    pos_z,
    input  logic signed [17:0]    quat_w,
    input  logic signed [17:0]    quat_x,
    input  logic signed [17:0]    quat_y,
    input  logic signed [17:0]    quat_z,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    new_pos_x,
    output logic signed [31:0]    new_pos_y,
    output logic signed [31:0]    new_pos_z,
    output logic signed [17:0]    new_quat_w,
    output logic signed [17:0]    new_quat_x,
    output logic signed [17:0]    new_quat_y,
    output logic signed [17:0]    new_quat_z
);

    localparam int Q_W    = prai_pkg::Q_W;
    localparam int D_W    = prai_pkg::D_W;
    localparam int DOT_W  = prai_pkg::DOT_W;
    localparam int DOTR_W = prai_pkg::DOTR_W;
    localparam int TERM_W = prai_pkg::TERM_W;
    localparam int TR_W   = prai_pkg::TR_W;
    localparam int R_W    = prai_pkg::R_W;
    localparam int OMC_W  = prai_pkg::OMC_W;

    logic signed [31:0]          org_reg [3];
    logic signed [Q_W-1:0]       axis_reg [3];
    logic signed [Q_W-1:0]       angle_reg;
    logic signed [Q_W-1:0]       ax_c [3];
    logic signed [Q_W-1:0]       ang_c;
    logic                        cfg_we;
    logic                        stale_reg, stale_next;
    logic [1:0]                  settle_reg, settle_next;
    logic                        coef_ok, trig_start, trig_busy;
    prai_pkg::trig_t             trig_full, trig_half;
    logic signed [prai_pkg::Z_W-1:0] ang_full, ang_half;

    logic signed [Q_W-1:0]       c_reg, s_reg, ch_reg, sh_reg;
    logic signed [OMC_W-1:0]     omc_reg;
    logic signed [Q_W-1:0]       q_reg [4];
    logic signed [35:0]          qp [3];
    logic signed [35:0]          qs [3];

    logic                        en1, en2, en3, en4, en5, accept;
    logic                        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [D_W-1:0]       d1_reg [3], d1_next [3];
    logic signed [Q_W-1:0]       p1_reg [4], p1_next [4];

    logic signed [DOT_W-1:0]     dot2_reg, dot2_next;
    logic signed [DOT_W-1:0]     cr2_reg [3], cr2_next [3];
    logic signed [D_W-1:0]       d2_reg [3];
    logic signed [R_W-1:0]       r2_reg [4], r2_next [4];

    logic signed [DOT_W-1:0]     dot_sh;
    logic signed [DOT_W-1:0]     cr_sh [3];
    logic signed [DOTR_W-1:0]    dot_r;
    logic signed [DOTR_W-1:0]    cr_r [3];
    logic signed [R_W-1:0]       r_sh [4];
    logic signed [TERM_W-1:0]    dc3_reg [3], dc3_next [3];
    logic signed [TERM_W-1:0]    crs3_reg [3], crs3_next [3];
    logic signed [TERM_W-1:0]    tr3_reg [3], tr3_next [3];
    logic signed [Q_W-1:0]       qo3_reg [4], qo3_next [4];

    logic signed [TERM_W-1:0]    t_sh [3];
    logic signed [TR_W-1:0]      t_r [3];
    logic signed [TERM_W-1:0]    dc4_reg [3], crs4_reg [3], tm4_reg [3], tm4_next [3];
    logic signed [Q_W-1:0]       qo4_reg [4];

    logic signed [TERM_W-1:0]    sum5 [3], v_sh [3], v_o [3];
    logic signed [31:0]          po5_reg [3], po5_next [3];
    logic signed [Q_W-1:0]       qo5_reg [4];

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= prai_pkg::ONE_Q16;
            angle_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prai_pkg::REG_ORIGIN_X:   org_reg[0]  <= cfg_data;
                prai_pkg::REG_ORIGIN_Y:   org_reg[1]  <= cfg_data;
                prai_pkg::REG_ORIGIN_Z:   org_reg[2]  <= cfg_data;
                prai_pkg::REG_AXIS_X:     axis_reg[0] <= cfg_data[Q_W-1:0];
                prai_pkg::REG_AXIS_Y:     axis_reg[1] <= cfg_data[Q_W-1:0];
                prai_pkg::REG_AXIS_Z:     axis_reg[2] <= cfg_data[Q_W-1:0];
                prai_pkg::REG_TURN_ANGLE: angle_reg   <= cfg_data[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ax_c[i] = prai_pkg::clamp_unit(40'(axis_reg[i]));
        if (angle_reg > prai_pkg::ANGLE_LIMIT)
            ang_c = prai_pkg::ANGLE_LIMIT;
        else if (angle_reg < -prai_pkg::ANGLE_LIMIT)
            ang_c = -prai_pkg::ANGLE_LIMIT;
        else
            ang_c = angle_reg;
        ang_full = prai_pkg::Z_W'(ang_c) <<< 15;
        ang_half = prai_pkg::Z_W'(ang_c) <<< 14;
    end

    // trig sequencing
    assign trig_busy  = trig_full.busy || trig_half.busy;
    assign trig_start = stale_reg && !trig_busy;

    always_comb
    begin
        stale_next = stale_reg;
        if (trig_start)
            stale_next = 1'b0;
        if (cfg_we && (cfg_index == prai_pkg::REG_TURN_ANGLE))
            stale_next = 1'b1;
        if (cfg_we || trig_busy || stale_reg)
            settle_next = 2'd2;
        else if (settle_reg != 2'd0)
            settle_next = settle_reg - 2'd1;
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg  <= 1'b1;
            settle_reg <= 2'd2;
        end
        else
        begin
            stale_reg  <= stale_next;
            settle_reg <= settle_next;
        end
    end

    assign coef_ok = !stale_reg && !trig_busy && (settle_reg == 2'd0);

    prai_cordic #(.ITER(TRIG_ITERATIONS)) u_trig_full (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (ang_full),
        .trig  (trig_full)
    );

    prai_cordic #(.ITER(TRIG_ITERATIONS)) u_trig_half (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (ang_half),
        .trig  (trig_half)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qp[i] = ax_c[i] * sh_reg;
            qs[i] = (qp[i] + 36'sd32768) >>> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= trig_full.cos_v;
        s_reg    <= trig_full.sin_v;
        ch_reg   <= trig_half.cos_v;
        sh_reg   <= trig_half.sin_v;
        omc_reg  <= 19'sd65536 - OMC_W'(c_reg);
        q_reg[0] <= ch_reg;
        for (int i = 0; i < 3; i++)
            q_reg[i+1] <= qs[i][Q_W-1:0];
    end

    // pipeline flow
    assign en5      = !v5_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !coef_ok || !en1;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= accept;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: offsets and clamped orientation
    always_comb
    begin
        d1_next[0] = D_W'(pos_x) - D_W'(org_reg[0]);
        d1_next[1] = D_W'(pos_y) - D_W'(org_reg[1]);
        d1_next[2] = D_W'(pos_z) - D_W'(org_reg[2]);
        p1_next[0] = prai_pkg::clamp_unit(40'(quat_w));
        p1_next[1] = prai_pkg::clamp_unit(40'(quat_x));
        p1_next[2] = prai_pkg::clamp_unit(40'(quat_y));
        p1_next[3] = prai_pkg::clamp_unit(40'(quat_z));
    end

    // stage 2: dot, cross and quaternion products
    always_comb
    begin
        dot2_next = ax_c[0] * d1_reg[0] + ax_c[1] * d1_reg[1] + ax_c[2] * d1_reg[2];
        cr2_next[0] = ax_c[1] * d1_reg[2] - ax_c[2] * d1_reg[1];
        cr2_next[1] = ax_c[2] * d1_reg[0] - ax_c[0] * d1_reg[2];
        cr2_next[2] = ax_c[0] * d1_reg[1] - ax_c[1] * d1_reg[0];
        r2_next[0] = q_reg[0] * p1_reg[0] - q_reg[1] * p1_reg[1]
                   - q_reg[2] * p1_reg[2] - q_reg[3] * p1_reg[3];
        r2_next[1] = q_reg[0] * p1_reg[1] + q_reg[1] * p1_reg[0]
                   + q_reg[2] * p1_reg[3] - q_reg[3] * p1_reg[2];
        r2_next[2] = q_reg[0] * p1_reg[2] - q_reg[1] * p1_reg[3]
                   + q_reg[2] * p1_reg[0] + q_reg[3] * p1_reg[1];
        r2_next[3] = q_reg[0] * p1_reg[3] + q_reg[1] * p1_reg[2]
                   - q_reg[2] * p1_reg[1] + q_reg[3] * p1_reg[0];
    end

    // stage 3: round, scale by cos and sin, project onto axis
    always_comb
    begin
        dot_sh = (dot2_reg + DOT_W'(32768)) >>> 16;
        dot_r  = dot_sh[DOTR_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            cr_sh[i]     = (cr2_reg[i] + DOT_W'(32768)) >>> 16;
            cr_r[i]      = cr_sh[i][DOTR_W-1:0];
            dc3_next[i]  = d2_reg[i] * c_reg;
            crs3_next[i] = cr_r[i] * s_reg;
            tr3_next[i]  = ax_c[i] * dot_r;
        end
        for (int i = 0; i < 4; i++)
        begin
            r_sh[i]     = (r2_reg[i] + R_W'(32768)) >>> 16;
            qo3_next[i] = prai_pkg::clamp_unit(40'(r_sh[i]));
        end
    end

    // stage 4: axis term times (1 - cos)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_sh[i]     = (tr3_reg[i] + TERM_W'(32768)) >>> 16;
            t_r[i]      = t_sh[i][TR_W-1:0];
            tm4_next[i] = t_r[i] * omc_reg;
        end
    end

    // stage 5: sum, round, restore origin, saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum5[i] = dc4_reg[i] + crs4_reg[i] + tm4_reg[i];
            v_sh[i] = (sum5[i] + TERM_W'(32768)) >>> 16;
            v_o[i]  = v_sh[i] + TERM_W'(org_reg[i]);
            if (v_o[i] > TERM_W'(64'sd2147483647))
                po5_next[i] = 32'sh7fffffff;
            else if (v_o[i] < -TERM_W'(64'sd2147483648))
                po5_next[i] = 32'sh80000000;
            else
                po5_next[i] = v_o[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && accept)
        begin
            d1_reg <= d1_next;
            p1_reg <= p1_next;
        end
        if (en2 && v1_reg)
        begin
            dot2_reg <= dot2_next;
            cr2_reg  <= cr2_next;
            d2_reg   <= d1_reg;
            r2_reg   <= r2_next;
        end
        if (en3 && v2_reg)
        begin
            dc3_reg  <= dc3_next;
            crs3_reg <= crs3_next;
            tr3_reg  <= tr3_next;
            qo3_reg  <= qo3_next;
        end
        if (en4 && v3_reg)
        begin
            dc4_reg  <= dc3_reg;
            crs4_reg <= crs3_reg;
            tm4_reg  <= tm4_next;
            qo4_reg  <= qo3_reg;
        end
        if (en5 && v4_reg)
        begin
            po5_reg <= po5_next;
            qo5_reg <= qo4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign new_pos_x  = po5_reg[0];
    assign new_pos_y  = po5_reg[1];
    assign new_pos_z  = po5_reg[2];
    assign new_quat_w = qo5_reg[0];
    assign new_quat_x = qo5_reg[1];
    assign new_quat_y = qo5_reg[2];
    assign new_quat_z = qo5_reg[3];

endmodule

### tb/tb_pose_rotation_about_axis.sv
`timescale 1ns / 1ps

module tb_pose_rotation_about_axis;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 12;
    localparam int  LONG_HOLD   = 300;
    localparam longint UNIT     = 65536;
    localparam longint ANG_MAX  = 102944;
    localparam longint PI30     = 64'sd3373259426;
    localparam longint HPI30    = 64'sd1686629713;
    localparam longint GAIN30   = 64'sd652032874;
    localparam int  CORDIC_STEPS = 16;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [17:0] qw;
        logic signed [17:0] qx;
        logic signed [17:0] qy;
        logic signed [17:0] qz;
    } pose_t;

    typedef struct {
        pose_t pose;
        bit    fixed_pos;
        logic signed [31:0] ex, ey, ez;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [17:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [17:0] new_quat_w, new_quat_x, new_quat_y, new_quat_z;

    pose_rotation_about_axis dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z),
        .new_quat_w(new_quat_w), .new_quat_x(new_quat_x),
        .new_quat_y(new_quat_y), .new_quat_z(new_quat_z)
    );

    logic signed [31:0] origin_sh [3];
    logic signed [17:0] axis_sh [3];
    logic signed [17:0] angle_sh;

    pose_t rotated_q[$];
    dir_row_t dir_rows[$];
    int  err_count;
    int  cycle_count = 0;
    int  poses_sent;
    int  poses_checked;
    int  settings_used;
    bit  quiet;
    bit  hold_req;
    int  stall_left;

    longint atan_tab [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097151, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_drop(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    task automatic cordic_cos_sin(input longint ang, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        x = GAIN30;
        y = 0;
        z = ang;
        flip = 0;
        if (z > HPI30)
        begin
            z -= PI30;
            flip = 1;
        end
        else if (z < -HPI30)
        begin
            z += PI30;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_tab[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip(round_drop(x, 14), -UNIT, UNIT);
        s = clip(round_drop(y, 14), -UNIT, UNIT);
    endtask

    task automatic rotate_pose(input pose_t p_in, output pose_t res);
        longint org[3], ax[3], d[3], cr[3], p[4], q[4], r[4];
        longint ang, c, s, ch, sh, dotv, omc, t, v;
        org[0] = origin_sh[0];
        org[1] = origin_sh[1];
        org[2] = origin_sh[2];
        for (int i = 0; i < 3; i++)
            ax[i] = clip(axis_sh[i], -UNIT, UNIT);
        d[0] = longint'(p_in.px) - org[0];
        d[1] = longint'(p_in.py) - org[1];
        d[2] = longint'(p_in.pz) - org[2];
        p[0] = clip(p_in.qw, -UNIT, UNIT);
        p[1] = clip(p_in.qx, -UNIT, UNIT);
        p[2] = clip(p_in.qy, -UNIT, UNIT);
        p[3] = clip(p_in.qz, -UNIT, UNIT);
        ang = clip(angle_sh, -ANG_MAX, ANG_MAX);
        cordic_cos_sin(ang * 32768, c, s);
        cordic_cos_sin(ang * 16384, ch, sh);
        dotv = round_drop(ax[0] * d[0] + ax[1] * d[1] + ax[2] * d[2], 16);
        cr[0] = round_drop(ax[1] * d[2] - ax[2] * d[1], 16);
        cr[1] = round_drop(ax[2] * d[0] - ax[0] * d[2], 16);
        cr[2] = round_drop(ax[0] * d[1] - ax[1] * d[0], 16);
        omc = UNIT - c;
        for (int i = 0; i < 3; i++)
        begin
            t = round_drop(ax[i] * dotv, 16);
            v = round_drop(d[i] * c + cr[i] * s + t * omc, 16) + org[i];
            r[i] = clip(v, -64'sd2147483648, 64'sd2147483647);
        end
        res.px = 32'(r[0]);
        res.py = 32'(r[1]);
        res.pz = 32'(r[2]);
        q[0] = ch;
        for (int i = 0; i < 3; i++)
            q[1 + i] = round_drop(ax[i] * sh, 16);
        r[0] = q[0] * p[0] - q[1] * p[1] - q[2] * p[2] - q[3] * p[3];
        r[1] = q[0] * p[1] + q[1] * p[0] + q[2] * p[3] - q[3] * p[2];
        r[2] = q[0] * p[2] - q[1] * p[3] + q[2] * p[0] + q[3] * p[1];
        r[3] = q[0] * p[3] + q[1] * p[2] - q[2] * p[1] + q[3] * p[0];
        for (int i = 0; i < 4; i++)
            r[i] = clip(round_drop(r[i], 16), -UNIT, UNIT);
        res.qw = 18'(r[0]);
        res.qx = 18'(r[1]);
        res.qy = 18'(r[2]);
        res.qz = 18'(r[3]);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(input prai_pkg::reg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            prai_pkg::REG_ORIGIN_X:   origin_sh[0] = data;
            prai_pkg::REG_ORIGIN_Y:   origin_sh[1] = data;
            prai_pkg::REG_ORIGIN_Z:   origin_sh[2] = data;
            prai_pkg::REG_AXIS_X:     axis_sh[0] = data[17:0];
            prai_pkg::REG_AXIS_Y:     axis_sh[1] = data[17:0];
            prai_pkg::REG_AXIS_Z:     axis_sh[2] = data[17:0];
            prai_pkg::REG_TURN_ANGLE: angle_sh = data[17:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (rotated_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_pose(input pose_t p, input bit fixed_pos,
                             input logic signed [31:0] ex, ey, ez);
        int gap;
        pose_t res;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z} <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rotate_pose(p, res);
        if (fixed_pos)
        begin
            res.px = ex;
            res.py = ey;
            res.pz = ez;
        end
        rotated_q.push_back(res);
        poses_sent++;
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
        begin
            p.px = $signed($urandom_range(0, 2000000)) - 1000000;
            p.py = $signed($urandom_range(0, 2000000)) - 1000000;
            p.pz = $signed($urandom_range(0, 2000000)) - 1000000;
        end
        else
        begin
            p.px = $urandom;
            p.py = $urandom;
            p.pz = $urandom;
        end
        if (mode == 9)
        begin
            p.qw = 18'($urandom);
            p.qx = 18'($urandom);
            p.qy = 18'($urandom);
            p.qz = 18'($urandom);
        end
        else
        begin
            p.qw = 18'($signed($urandom_range(0, 131072)) - 65536);
            p.qx = 18'($signed($urandom_range(0, 131072)) - 65536);
            p.qy = 18'($signed($urandom_range(0, 131072)) - 65536);
            p.qz = 18'($signed($urandom_range(0, 131072)) - 65536);
        end
        return p;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            err_count++;
            $display("%0t %s mismatch: expected %0d got %0d", $realtime, name, want, got);
        end
    endtask

    initial
    begin
        pose_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t unexpected result transfer", $realtime);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("new_pos_x", want.px, longint'(new_pos_x));
                    check_field("new_pos_y", want.py, longint'(new_pos_y));
                    check_field("new_pos_z", want.pz, longint'(new_pos_z));
                    check_field("new_quat_w", want.qw, longint'(new_quat_w));
                    check_field("new_quat_x", want.qx, longint'(new_quat_x));
                    check_field("new_quat_y", want.qy, longint'(new_quat_y));
                    check_field("new_quat_z", want.qz, longint'(new_quat_z));
                    poses_checked++;
                end
            end
        end
    end

    initial
    begin
        int n;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                n = pick_gap();
                out_stall <= (n > 0);
                if (n > 0)
                    stall_left = n - 1;
            end
        end
    end

    task automatic add_row(input pose_t p, input bit fixed_pos,
                           input logic signed [31:0] ex, ey, ez);
        dir_row_t row;
        row.pose = p;
        row.fixed_pos = fixed_pos;
        row.ex = ex;
        row.ey = ey;
        row.ez = ez;
        dir_rows.push_back(row);
    endtask

    task automatic apply_setting(input int k);
        logic [31:0] o[3];
        logic [17:0] a[3];
        logic [17:0] ang;
        int axis_pick;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = ($urandom_range(0, 1)) ? $urandom
                 : 32'($signed($urandom_range(0, 4000000)) - 2000000);
            a[i] = 18'd0;
        end
        axis_pick = $urandom_range(0, 6);
        case (axis_pick)
            0: a[0] = 18'sd65536;
            1: a[1] = -18'sd65536;
            2: a[2] = 18'sd65536;
            3:
            begin
                a[0] = 18'sd46341;
                a[1] = -18'sd46341;
            end
            4:
            begin
                a[0] = 18'sd37837;
                a[1] = 18'sd37837;
                a[2] = -18'sd37837;
            end
            default:
            begin
                a[0] = 18'($urandom);
                a[1] = 18'($urandom);
                a[2] = 18'($urandom);
            end
        endcase
        ang = 18'($signed($urandom_range(0, 205888)) - 102944);
        case (k)
            0: ang = 18'sd102944;
            1: ang = -18'sd102944;
            2:
            begin
                ang = 18'sd131071;
                a[0] = 18'sd131071;
                a[1] = 18'sh20000;
                a[2] = 18'sd0;
            end
            3:
            begin
                ang = 18'sh20000;
                a[0] = 18'sd0;
                a[1] = 18'sd0;
                a[2] = 18'sd0;
            end
            4:
            begin
                o[0] = 32'h7fffffff;
                o[1] = 32'h80000000;
                o[2] = 32'h7fffffff;
                ang = 18'sd51472;
            end
            5: ang = -18'sd51473;
            6: ang = 18'sd0;
            default: ;
        endcase
        wait_idle();
        write_reg(prai_pkg::REG_ORIGIN_X, o[0]);
        write_reg(prai_pkg::REG_ORIGIN_Y, o[1]);
        write_reg(prai_pkg::REG_ORIGIN_Z, o[2]);
        write_reg(prai_pkg::REG_AXIS_X, {14'($urandom_range(0, 16383)), a[0]});
        write_reg(prai_pkg::REG_AXIS_Y, {14'($urandom_range(0, 16383)), a[1]});
        write_reg(prai_pkg::REG_AXIS_Z, {14'($urandom_range(0, 16383)), a[2]});
        write_reg(prai_pkg::REG_TURN_ANGLE, {14'($urandom_range(0, 16383)), ang});
        if (k % 5 == 2)
            write_reg(prai_pkg::reg_idx_t'(3'd7), $urandom);
        settings_used++;
    endtask

    initial
    begin
        pose_t p;
        int per_phase;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z} = '0;
        err_count = 0;
        poses_sent = 0;
        poses_checked = 0;
        settings_used = 1;
        quiet = 0;
        hold_req = 0;
        origin_sh = '{32'sd0, 32'sd0, 32'sd0};
        axis_sh = '{18'sd0, 18'sd0, 18'sd65536};
        angle_sh = 18'sd0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row('{32'sd0, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0, 18'sd0},
                1, 32'sd0, 32'sd0, 32'sd0);
        add_row('{32'sd0, 32'sd0, 32'sd0, 18'sd131071, 18'sh20000, 18'sd0, 18'sd0},
                1, 32'sd0, 32'sd0, 32'sd0);
        add_row('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  18'sd65536, 18'sd65536, 18'sd65536, 18'sd65536}, 0, 0, 0, 0);
        add_row('{32'h80000000, 32'h80000000, 32'h80000000,
                  -18'sd65536, -18'sd65536, -18'sd65536, -18'sd65536}, 0, 0, 0, 0);
        add_row('{32'h7fffffff, 32'h80000000, 32'sd65536,
                  18'sd0, 18'sd65536, 18'sd0, 18'sd0}, 0, 0, 0, 0);
        add_row('{32'sd65536, -32'sd65536, 32'sd1, 18'sd0, 18'sd0, 18'sd65536, 18'sd0},
                0, 0, 0, 0);
        add_row('{-32'sd1, 32'sd1, -32'sd1, 18'sd0, 18'sd0, 18'sd0, 18'sd65536},
                0, 0, 0, 0);
        add_row('{32'sd123456, 32'sd0, 32'sd0, 18'sd131071, 18'sd131071,
                  18'sh20000, 18'sh20000}, 0, 0, 0, 0);
        add_row('{32'sd0, 32'sd0, 32'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
                1, 32'sd0, 32'sd0, 32'sd0);
        add_row('{32'haaaaaaaa, 32'h55555555, 32'hffffffff,
                  18'sh2aaaa, 18'sh15555, 18'sh3ffff, 18'sh00001}, 0, 0, 0, 0);

        foreach (dir_rows[i])
            send_pose(dir_rows[i].pose, dir_rows[i].fixed_pos,
                      dir_rows[i].ex, dir_rows[i].ey, dir_rows[i].ez);
        end_burst();

        per_phase = 100;
        for (int k = 0; k < 20; k++)
        begin
            apply_setting(k);
            quiet = (k % 4 == 3);
            if (k == 8)
                hold_req = 1;
            for (int j = 0; j < per_phase; j++)
            begin
                p = random_pose();
                send_pose(p, 0, 0, 0, 0);
                if (k == 10 && j == per_phase / 2)
                begin
                    end_burst();
                    wait (rotated_q.size() == 0);
                end
            end
            end_burst();
            quiet = 0;
        end

        wait (rotated_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d poses, checked %0d results, over %0d register settings",
                 poses_sent, poses_checked, settings_used);
        $display("mismatches: %0d", err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
